// ===== rtl/arp_pkg.sv =====
// Shared constants, codes and helpers for the ARP address cache.
`default_nettype none
package arp_pkg;

  localparam int ENTRIES_DEFAULT = 32;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_HIT       = 3'd3;
  localparam logic [2:0] ST_MISS      = 3'd4;
  localparam logic [2:0] ST_MCAST     = 3'd5;

  localparam logic [7:0]  MCAST_MASK = 8'hE0;
  localparam logic [23:0] MCAST_OUI  = 24'h01005E;

  function automatic logic is_mcast(input logic [31:0] ip);
    return (ip[7:0] & MCAST_MASK) == MCAST_MASK;
  endfunction

  function automatic logic [47:0] mcast_mac(input logic [31:0] ip);
    return {MCAST_OUI, 1'b0, ip[14:8], ip[23:16], ip[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/arp_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module arp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/arp_address_cache.sv =====
// ARP address cache: fill-only IPv4-to-MAC table with sequential scan.
//
// Input channel (in_valid/in_ready) carries action, ip_addr and mac_in.
// action 0 appends the pair unless the address is present or the table
// is full; action 1 looks the address up. Multicast lookups map to
// 01:00:5E plus the low 23 address bits and never read the table.
// Output channel (out_valid/out_ready) carries status, mac_out and
// entry_count, one result beat per input beat, in order.
// Items that search the table do one address-memory read per cycle,
// walking the filled entries in order and stopping at the first hit.
// Multicast, address-zero lookups and updates to a full table go
// straight to the result without a scan.
// The result sits in an output register; a new item is accepted while
// it waits. If the receiver stalls, the next result is held internally
// and no further item is accepted until the register frees up.
// Reset clears the fill count and the output valid; the memories hold
// no state that matters until written, so no clearing pass is needed.
`default_nettype none
module arp_address_cache
  import arp_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [31:0] ip_addr,
  input  wire logic [47:0] mac_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [47:0]      mac_out,
  output logic [5:0]       entry_count
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > 6) ? CW : 6;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t          state;
  logic [CW-1:0]   fill;
  logic [CW-1:0]   scan_idx;
  logic            pend;
  logic            item_action;
  logic [31:0]     item_ip;
  logic [47:0]     item_mac;
  logic [2:0]      res_status;
  logic [47:0]     res_mac;

  logic [31:0]     addr_rdata;
  logic [47:0]     mac_rdata;
  logic            hit;
  logic            scan_end;
  logic            wr_en;
  logic [EW-1:0]   fill_ext;

  assign in_ready = (state == S_IDLE);
  assign hit      = pend && (addr_rdata == item_ip);
  assign scan_end = (scan_idx == fill);
  assign wr_en    = (state == S_SCAN) && !hit && scan_end && (item_action == ACT_UPDATE);
  assign fill_ext = EW'(fill);

  arp_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_addr_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill[AW-1:0]),
    .wdata (item_ip),
    .raddr (scan_idx[AW-1:0]),
    .rdata (addr_rdata)
  );

  arp_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_mac_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill[AW-1:0]),
    .wdata (item_mac),
    .raddr (scan_idx[AW-1:0]),
    .rdata (mac_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      scan_idx  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_action <= action;
            item_ip     <= ip_addr;
            item_mac    <= mac_in;
            pend        <= 1'b0;
            scan_idx    <= '0;
            res_mac     <= '0;
            if (action == ACT_LOOKUP && is_mcast(ip_addr)) begin
              res_status <= ST_MCAST;
              res_mac    <= mcast_mac(ip_addr);
              state      <= S_FINISH;
            end else if (action == ACT_LOOKUP && ip_addr == 32'd0) begin
              res_status <= ST_MISS;
              state      <= S_FINISH;
            end else if (action == ACT_UPDATE && fill == CW'(ENTRIES)) begin
              res_status <= ST_FULL;
              state      <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (item_action == ACT_LOOKUP) begin
              res_status <= ST_HIT;
              res_mac    <= mac_rdata;
            end else begin
              res_status <= ST_DUPLICATE;
            end
            state <= S_FINISH;
          end else if (scan_end) begin
            if (item_action == ACT_LOOKUP) begin
              res_status <= ST_MISS;
            end else begin
              res_status <= ST_STORED;
              fill       <= fill + 1'b1;
            end
            state <= S_FINISH;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            pend     <= 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            mac_out     <= res_mac;
            entry_count <= fill_ext[5:0];
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/arp_checker.sv =====
// Port-level checks for the ARP address cache, bound to the top level.
`default_nettype none
module arp_checker
  import arp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [47:0] mac_out,
  input wire logic [5:0]  entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(mac_out)
      && $stable(entry_count))
    else $error("result beat changed while stalled");

  a_mac_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_HIT && status != ST_MCAST |-> mac_out == 48'd0)
    else $error("nonzero MAC on a status that carries none");

  a_mcast_oui: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MCAST |-> mac_out[47:23] == {MCAST_OUI, 1'b0})
    else $error("multicast MAC prefix wrong");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input beat accepted while another is in flight");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind arp_address_cache arp_checker u_arp_checker (.*);
`default_nettype wire

// ===== sim/arp_address_cache_check.sv =====
`timescale 1ns / 1ps
// Checker for the ARP address cache: watches both channels, predicts each reply and compares.
module arp_address_cache_check
  import arp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        action,
  input  wire logic [31:0] ip_addr,
  input  wire logic [47:0] mac_in,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  status,
  input  wire logic [47:0] mac_out,
  input  wire logic [5:0]  entry_count,
  output int               pending,
  output int               mismatches
);

  localparam int          ENTRIES      = ENTRIES_DEFAULT;
  localparam logic [47:0] GROUP_PREFIX = 48'h01_00_5E_00_00_00;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] mac;
    logic [5:0]  count;
  } arp_reply_t;

  logic [31:0] ip_table  [ENTRIES];
  logic [47:0] mac_table [ENTRIES];
  int          fill_level;
  int          mismatch_count = 0;
  arp_reply_t  expected_replies [$];

  function automatic int find_entry(input logic [31:0] ip);
    for (int k = 0; k < fill_level; k++) begin
      if (ip_table[k] == ip) return k;
    end
    return -1;
  endfunction

  function automatic arp_reply_t arp_resolve(input logic act, input logic [31:0] ip,
                                             input logic [47:0] mac);
    arp_reply_t reply;
    int         slot;
    reply = '0;
    slot  = find_entry(ip);
    if (act == ACT_UPDATE) begin
      if (fill_level >= ENTRIES) begin
        reply.status = ST_FULL;
      end else if (slot >= 0) begin
        reply.status = ST_DUPLICATE;
      end else begin
        ip_table[fill_level]  = ip;
        mac_table[fill_level] = mac;
        fill_level++;
        reply.status = ST_STORED;
      end
    end else if (&ip[7:5]) begin
      reply.status = ST_MCAST;
      reply.mac    = GROUP_PREFIX | {25'd0, ip[14:8], ip[23:16], ip[31:24]};
    end else if (ip == 32'd0 || slot < 0) begin
      reply.status = ST_MISS;
    end else begin
      reply.status = ST_HIT;
      reply.mac    = mac_table[slot];
    end
    reply.count = 6'(fill_level);
    return reply;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatch_count++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    arp_reply_t want;
    if (rst) begin
      fill_level = 0;
      expected_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result beat with nothing expected", 48'(status), 48'd0);
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status)
            report_mismatch("status", 48'(status), 48'(want.status));
          if (mac_out !== want.mac)
            report_mismatch("mac_out", mac_out, want.mac);
          if (entry_count !== want.count)
            report_mismatch("entry_count", 48'(entry_count), 48'(want.count));
        end
      end
      if (in_valid && in_ready)
        expected_replies.push_back(arp_resolve(action, ip_addr, mac_in));
    end
    pending    <= expected_replies.size();
    mismatches <= mismatch_count;
  end

endmodule

// ===== sim/arp_address_cache_test.sv =====
`timescale 1ns / 1ps
// Top of the ARP address cache regression: stimulus, channel pacing and verdict.
module arp_address_cache_test;
  import arp_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int DRAIN_LIMIT  = 20000;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        action      = ACT_UPDATE;
  logic [31:0] ip_addr     = 32'd0;
  logic [47:0] mac_in      = 48'd0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  status;
  logic [47:0] mac_out;
  logic [5:0]  entry_count;
  int          pending;
  int          mismatches;

  int          burst_left  = 1;
  int          stall_mode  = 0;
  int          stall_left  = 0;
  int          tick        = 0;
  logic [31:0] known_ips [$];

  arp_address_cache u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .ip_addr    (ip_addr),
    .mac_in     (mac_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .mac_out    (mac_out),
    .entry_count(entry_count)
  );

  arp_address_cache_check u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .ip_addr    (ip_addr),
    .mac_in     (mac_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .mac_out    (mac_out),
    .entry_count(entry_count),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("arp_address_cache regression: fail");
    $finish;
  end

  // Stall the result channel in phases: open, light, heavy, periodic.
  always @(posedge clk) begin
    tick <= tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((tick % 37) >= 20);
    endcase
  end

  // Hold the beat until accepted, then pause at the end of a burst.
  task automatic send_request(input logic act, input logic [31:0] ip, input logic [47:0] mac);
    int gap;
    in_valid <= 1'b1;
    action   <= act;
    ip_addr  <= ip;
    mac_in   <= mac;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
  endtask

  initial begin
    int          pick;
    int          waited;
    logic        act;
    logic [31:0] ip;
    logic [47:0] mac;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    send_request(ACT_LOOKUP, 32'h0100_000A, 48'h0);
    send_request(ACT_UPDATE, 32'h0000_0000, 48'h0);
    send_request(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    send_request(ACT_UPDATE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_request(ACT_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_request(ACT_LOOKUP, 32'h0000_00E0, 48'h0);
    send_request(ACT_LOOKUP, 32'hFFFF_FFDF, 48'h0);
    send_request(ACT_UPDATE, 32'hFFFF_FFDF, 48'h1234_5678_9ABC);
    send_request(ACT_LOOKUP, 32'hFFFF_FFDF, 48'h0);
    send_request(ACT_UPDATE, 32'h0100_000A, 48'h0);
    send_request(ACT_LOOKUP, 32'h0100_000A, 48'hFFFF_FFFF_FFFF);
    send_request(ACT_UPDATE, 32'h0100_000A, 48'hA5A5_A5A5_A5A5);
    send_request(ACT_LOOKUP, 32'h0100_000A, 48'h0);
    send_request(ACT_LOOKUP, 32'h5A3C_FFEF, 48'h0);
    send_request(ACT_LOOKUP, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);
    send_request(ACT_LOOKUP, 32'h0000_00FF, 48'h0);
    known_ips.push_back(32'hFFFF_FFDF);
    known_ips.push_back(32'h0100_000A);
    known_ips.push_back(32'hFFFF_FFFF);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mac  = {16'($urandom), 32'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        act = ACT_UPDATE;
        if ($urandom_range(0, 4) < 2) begin
          ip = $urandom;
          known_ips.push_back(ip);
        end else begin
          ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
        end
      end else begin
        act  = ACT_LOOKUP;
        pick = $urandom_range(0, 99);
        if (pick < 45)
          ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
        else if (pick < 65)
          ip = $urandom | 32'h0000_00E0;
        else if (pick < 70)
          ip = 32'd0;
        else
          ip = $urandom;
      end
      send_request(act, ip, mac);
    end

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);

    if (pending != 0) begin
      $display("arp_address_cache regression: fail");
      $finish;
    end else begin
      repeat (ENTRIES_DEFAULT + 8) @(posedge clk);
      if (mismatches == 0 && pending == 0)
        $display("arp_address_cache regression: pass");
      else
        $display("arp_address_cache regression: fail");
      $finish;
    end
  end

endmodule
